### hw/rtl/position_reply_link_macros.svh
// ----------------------------------------------------------------------------
// position_reply_link assertion macros
// shared assertion wrappers for the position reply link
// ----------------------------------------------------------------------------
`ifndef POSITION_REPLY_LINK_MACROS_SVH
`define POSITION_REPLY_LINK_MACROS_SVH

// same-cycle implication, disabled in reset
`define PRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("position_reply_link assertion failed");

// next-cycle implication, disabled in reset
`define PRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("position_reply_link assertion failed");

`endif

### hw/rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// constants and shared types of the position reply link
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prl_pkg;

  localparam int FRAME_LENGTH  = 8;
  localparam int FRAME_INDEX_W = $clog2(FRAME_LENGTH);
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0]  CODE_POSITION = 8'h36;
  localparam logic [7:0]  FRAME_TRAILER = 8'h6B;
  localparam logic [31:0] MAG_LIMIT     = 32'h7FFF_FFFF;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET     = 8'd1;
  localparam logic [15:0] QUERY_PERIOD_RESET       = 16'd0;
  localparam logic [15:0] REQUEST_TIMEOUT_RESET    = 16'd30;

  localparam logic ACTION_RX_BYTE = 1'b0;
  localparam logic ACTION_TICK    = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEVICE_ADDRESS  = 2'd0,
    CFG_QUERY_PERIOD    = 2'd1,
    CFG_REQUEST_TIMEOUT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic               frame_ok;
    logic signed [31:0] position;
    logic               position_valid;
  } parse_status_t;

  typedef struct packed {
    logic        send;
    logic        request_pending;
    logic [31:0] age_ms;
  } poll_status_t;

endpackage

### hw/rtl/prl_in_if.sv
// ----------------------------------------------------------------------------
// prl_in_if
// input channel: received byte or millisecond tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prl_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic       tx_busy;

  modport source (output valid, output action, output rx_byte, output tx_busy,
                  input ready);
  modport sink   (input valid, input action, input rx_byte, input tx_busy,
                  output ready);
endinterface

### hw/rtl/prl_out_if.sv
// ----------------------------------------------------------------------------
// prl_out_if
// result channel: request bytes and position status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prl_out_if;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               last;
  logic signed [31:0] position;
  logic               position_valid;
  logic [31:0]        age_ms;
  logic               request_pending;

  modport source (output valid, output tx_valid, output tx_byte, output last,
                  output position, output position_valid, output age_ms,
                  output request_pending, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input last,
                  input position, input position_valid, input age_ms,
                  input request_pending, output ready);
endinterface

### hw/rtl/prl_parser.sv
// ----------------------------------------------------------------------------
// prl_parser
// reply frame parser, holds the latest position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prl_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            device_address,
  output prl_pkg::parse_status_t status
);

  localparam int IW = prl_pkg::FRAME_INDEX_W;
  localparam logic [IW-1:0] IDX_ADDR    = IW'(0);
  localparam logic [IW-1:0] IDX_CODE    = IW'(1);
  localparam logic [IW-1:0] IDX_TRAILER = IW'(prl_pkg::FRAME_LENGTH - 1);

  logic [IW-1:0]      frame_index_r, frame_index_nxt;
  logic [7:0]         frame_bytes_r [2:prl_pkg::FRAME_LENGTH-2];
  logic signed [31:0] position_r, position_nxt;
  logic               have_position_r, have_position_nxt;
  logic               frame_done;
  logic               frame_ok;
  logic [31:0]        mag;
  logic [31:0]        mag_sat;

  always_comb begin
    frame_index_nxt = frame_index_r;
    frame_done      = 1'b0;
    if (take) begin
      if (frame_index_r == IDX_ADDR) begin
        if (rx_byte == device_address) frame_index_nxt = IDX_CODE;
      end else if (frame_index_r == IDX_CODE) begin
        if (rx_byte == prl_pkg::CODE_POSITION) begin
          frame_index_nxt = frame_index_r + IW'(1);
        end else if (rx_byte != device_address) begin
          frame_index_nxt = IDX_ADDR;
        end
      end else if (frame_index_r == IDX_TRAILER) begin
        frame_index_nxt = IDX_ADDR;
        frame_done      = 1'b1;
      end else begin
        frame_index_nxt = frame_index_r + IW'(1);
      end
    end
  end

  assign mag = {frame_bytes_r[3], frame_bytes_r[4], frame_bytes_r[5], frame_bytes_r[6]};
  assign mag_sat = mag[31] ? prl_pkg::MAG_LIMIT : mag;

  assign frame_ok = frame_done && (rx_byte == prl_pkg::FRAME_TRAILER)
                    && (frame_bytes_r[2] <= 8'd1);

  always_comb begin
    position_nxt      = position_r;
    have_position_nxt = have_position_r;
    if (frame_ok) begin
      position_nxt      = frame_bytes_r[2][0] ? -$signed(mag_sat) : $signed(mag_sat);
      have_position_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_index_r   <= IDX_ADDR;
      position_r      <= '0;
      have_position_r <= 1'b0;
    end else begin
      frame_index_r   <= frame_index_nxt;
      position_r      <= position_nxt;
      have_position_r <= have_position_nxt;
    end
  end

  // payload bytes only, address code and trailer are checked on the fly
  always_ff @(posedge clk) begin
    for (int k = 2; k <= prl_pkg::FRAME_LENGTH - 2; k++) begin
      if (take && frame_index_r == IW'(k)) frame_bytes_r[k] <= rx_byte;
    end
  end

  assign status.frame_ok       = frame_ok;
  assign status.position       = position_nxt;
  assign status.position_valid = have_position_nxt;

endmodule

### hw/rtl/prl_poll.sv
// ----------------------------------------------------------------------------
// prl_poll
// millisecond time base and request scheduling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prl_poll (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  input  logic                 tx_busy,
  input  logic                 frame_ok,
  input  logic [15:0]          query_period,
  input  logic [15:0]          request_timeout_ms,
  output prl_pkg::poll_status_t status
);

  logic [31:0] current_time_r, current_time_nxt;
  // request and query times always move together, one register serves both
  logic [31:0] query_time_r, query_time_nxt;
  logic [31:0] update_time_r, update_time_nxt;
  logic        waiting_r, waiting_nxt;
  logic [31:0] since_query;
  logic        due;
  logic        blocked;
  logic        send;

  assign current_time_nxt = tick ? current_time_r + 32'd1 : current_time_r;
  assign since_query      = current_time_nxt - query_time_r;

  assign due     = (query_period != 16'd0) && (since_query >= {16'd0, query_period});
  assign blocked = waiting_r && (since_query < {16'd0, request_timeout_ms});
  assign send    = tick && due && !blocked && !tx_busy;

  always_comb begin
    waiting_nxt     = waiting_r;
    query_time_nxt  = query_time_r;
    update_time_nxt = update_time_r;
    if (send) begin
      waiting_nxt    = 1'b1;
      query_time_nxt = current_time_nxt;
    end else if (frame_ok) begin
      waiting_nxt     = 1'b0;
      update_time_nxt = current_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_time_r <= '0;
      query_time_r   <= '0;
      update_time_r  <= '0;
      waiting_r      <= 1'b0;
    end else begin
      current_time_r <= current_time_nxt;
      query_time_r   <= query_time_nxt;
      update_time_r  <= update_time_nxt;
      waiting_r      <= waiting_nxt;
    end
  end

  assign status.send            = send;
  assign status.request_pending = waiting_nxt;
  assign status.age_ms          = current_time_nxt - update_time_nxt;

endmodule

### hw/rtl/prl_out.sv
// ----------------------------------------------------------------------------
// prl_out
// result register and request byte sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prl_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  prl_pkg::parse_status_t parse,
  input  prl_pkg::poll_status_t  poll,
  input  logic [7:0]             device_address,
  output logic                   can_load,
  prl_out_if.source              out_ch
);

  typedef enum logic [2:0] {
    BEAT_NONE,
    BEAT_SINGLE,
    BEAT_ADDRESS,
    BEAT_CODE,
    BEAT_TRAILER
  } beat_t;

  beat_t              beat_r;
  logic [7:0]         tx_byte_r;
  logic signed [31:0] position_r;
  logic               position_valid_r;
  logic [31:0]        age_ms_r;
  logic               pending_r;
  logic               is_last;

  assign is_last  = (beat_r == BEAT_SINGLE) || (beat_r == BEAT_TRAILER);
  assign can_load = (beat_r == BEAT_NONE) || (out_ch.ready && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= BEAT_NONE;
    end else if (load) begin
      beat_r <= poll.send ? BEAT_ADDRESS : BEAT_SINGLE;
    end else if (out_ch.ready) begin
      unique case (beat_r)
        BEAT_NONE:    beat_r <= BEAT_NONE;
        BEAT_SINGLE:  beat_r <= BEAT_NONE;
        BEAT_ADDRESS: beat_r <= BEAT_CODE;
        BEAT_CODE:    beat_r <= BEAT_TRAILER;
        BEAT_TRAILER: beat_r <= BEAT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte_r        <= poll.send ? device_address : 8'd0;
      position_r       <= parse.position;
      position_valid_r <= parse.position_valid;
      age_ms_r         <= poll.age_ms;
      pending_r        <= poll.request_pending;
    end else if (out_ch.ready) begin
      if (beat_r == BEAT_ADDRESS) tx_byte_r <= prl_pkg::CODE_POSITION;
      else if (beat_r == BEAT_CODE) tx_byte_r <= prl_pkg::FRAME_TRAILER;
    end
  end

  assign out_ch.valid           = (beat_r != BEAT_NONE);
  assign out_ch.tx_valid        = (beat_r == BEAT_ADDRESS) || (beat_r == BEAT_CODE)
                                  || (beat_r == BEAT_TRAILER);
  assign out_ch.tx_byte         = tx_byte_r;
  assign out_ch.last            = is_last;
  assign out_ch.position        = position_r;
  assign out_ch.position_valid  = position_valid_r;
  assign out_ch.age_ms          = age_ms_r;
  assign out_ch.request_pending = pending_r;

endmodule

### hw/rtl/position_reply_link.sv
// ----------------------------------------------------------------------------
// position_reply_link
// polls a drive for its position and parses the position reply frames
// ----------------------------------------------------------------------------
// Each input word is a received UART byte or a one-millisecond tick. A word
// is held in an input register and processed in one pass into the result
// register, so a new word is taken every cycle while the result side keeps
// up and no request is under way. A byte, or a tick that sends nothing,
// gives one result word; a tick that sends a request gives three result
// words (address, 0x36, 0x6B) in order from the result register's byte
// sequencer, which takes no new word until the last one is accepted. Status
// fields show position, validity, age and pending after the word.
`timescale 1ns / 1ps
`include "position_reply_link_macros.svh"

module position_reply_link (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [prl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0]     cfg_data,
  prl_in_if.sink                             in_ch,
  prl_out_if.source                          out_ch
);

  logic [7:0]  device_address_r;
  logic [15:0] query_period_r;
  logic [15:0] request_timeout_r;

  logic        in_valid_r;
  logic        in_action_r;
  logic [7:0]  in_rx_byte_r;
  logic        in_tx_busy_r;

  logic        can_load;
  logic        advance;
  logic        in_take;

  prl_pkg::parse_status_t parse_status;
  prl_pkg::poll_status_t  poll_status;

  assign advance     = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r  <= prl_pkg::DEVICE_ADDRESS_RESET;
      query_period_r    <= prl_pkg::QUERY_PERIOD_RESET;
      request_timeout_r <= prl_pkg::REQUEST_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prl_pkg::CFG_DEVICE_ADDRESS:  device_address_r  <= cfg_data[7:0];
        prl_pkg::CFG_QUERY_PERIOD:    query_period_r    <= cfg_data;
        prl_pkg::CFG_REQUEST_TIMEOUT: request_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take || (in_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r  <= in_ch.action;
      in_rx_byte_r <= in_ch.rx_byte;
      in_tx_busy_r <= in_ch.tx_busy;
    end
  end

  prl_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (advance && (in_action_r == prl_pkg::ACTION_RX_BYTE)),
    .rx_byte        (in_rx_byte_r),
    .device_address (device_address_r),
    .status         (parse_status)
  );

  prl_poll u_poll (
    .clk                (clk),
    .rst_n              (rst_n),
    .tick               (advance && (in_action_r == prl_pkg::ACTION_TICK)),
    .tx_busy            (in_tx_busy_r),
    .frame_ok           (parse_status.frame_ok),
    .query_period       (query_period_r),
    .request_timeout_ms (request_timeout_r),
    .status             (poll_status)
  );

  prl_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance),
    .parse          (parse_status),
    .poll           (poll_status),
    .device_address (device_address_r),
    .can_load       (can_load),
    .out_ch         (out_ch)
  );

  `PRL_ASSERT_IMPL(a_mid_word_is_request, clk, rst_n,
                   out_ch.valid && !out_ch.last, out_ch.tx_valid)
  `PRL_ASSERT_IMPL(a_request_pending_on_send, clk, rst_n,
                   out_ch.valid && out_ch.tx_valid, out_ch.request_pending)
  `PRL_ASSERT_IMPL(a_trailer_ends_request, clk, rst_n,
                   out_ch.valid && out_ch.tx_valid && out_ch.last,
                   out_ch.tx_byte == prl_pkg::FRAME_TRAILER)
  `PRL_ASSERT_NEXT(a_request_continues, clk, rst_n,
                   out_ch.valid && out_ch.ready && !out_ch.last,
                   out_ch.valid && out_ch.tx_valid)

endmodule

### tb/position_reply_link_checker.sv
// ----------------------------------------------------------------------------
// position_reply_link_checker
// watches the input, result and register ports of the position reply link,
// keeps its own copy of the parser and poller state, works out the status
// words due for every accepted input word and compares each accepted result
// word with the oldest one due, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module position_reply_link_checker
  import prl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_action,
  input  logic [7:0]             in_rx_byte,
  input  logic                   in_tx_busy,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_tx_valid,
  input  logic [7:0]             out_tx_byte,
  input  logic                   out_last,
  input  logic [31:0]            out_position,
  input  logic                   out_position_valid,
  input  logic [31:0]            out_age_ms,
  input  logic                   out_request_pending,
  output int                     fail_count,
  output int                     words_due,
  output int                     results_seen,
  output int                     requests_seen,
  output int                     frames_taken
);

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] position;
    logic        position_valid;
    logic [31:0] age_ms;
    logic        request_pending;
  } status_word_t;

  logic [7:0]               dev_addr;
  logic [15:0]              poll_period;
  logic [15:0]              timeout_ms;
  logic [FRAME_INDEX_W-1:0] frame_pos;
  logic [7:0]               frame_buf [FRAME_LENGTH];
  logic [31:0]              held_position;
  logic [31:0]              update_ms;
  logic [31:0]              request_ms;
  logic [31:0]              query_ms;
  logic [31:0]              now_ms;
  logic                     have_fix;
  logic                     awaiting;
  status_word_t             status_due [$];

  function automatic status_word_t status_now(input logic tx_valid, input logic [7:0] tx_byte,
                                              input logic last);
    status_word_t w;
    w.tx_valid        = tx_valid;
    w.tx_byte         = tx_byte;
    w.last            = last;
    w.position        = held_position;
    w.position_valid  = have_fix;
    w.age_ms          = now_ms - update_ms;
    w.request_pending = awaiting;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result word %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    logic [31:0] mag;
    if (frame_pos == '0) begin
      if (b == dev_addr) begin
        frame_buf[0] = b;
        frame_pos    = FRAME_INDEX_W'(1);
      end
    end else if (frame_pos == FRAME_INDEX_W'(1)) begin
      // a repeated address keeps the parser waiting for the code
      if (b == CODE_POSITION) begin
        frame_buf[1] = b;
        frame_pos    = FRAME_INDEX_W'(2);
      end else if (b != dev_addr) begin
        frame_pos = '0;
      end
    end else begin
      frame_buf[frame_pos] = b;
      if (frame_pos != FRAME_INDEX_W'(FRAME_LENGTH - 1)) begin
        frame_pos = frame_pos + FRAME_INDEX_W'(1);
      end else begin
        frame_pos = '0;
        if (frame_buf[7] == FRAME_TRAILER && frame_buf[2] <= 8'd1) begin
          mag = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
          if (mag > MAG_LIMIT) mag = MAG_LIMIT;
          if (frame_buf[2] != 8'd0) mag = -mag;
          held_position = mag;
          update_ms     = now_ms;
          have_fix      = 1'b1;
          awaiting      = 1'b0;
          frames_taken++;
        end
      end
    end
  endtask

  task automatic predict_word(input logic action, input logic [7:0] b, input logic busy);
    logic poll_due;
    if (action == ACTION_RX_BYTE) begin
      take_rx_byte(b);
      status_due.push_back(status_now(1'b0, 8'h00, 1'b1));
    end else begin
      now_ms   = now_ms + 32'd1;
      // zero timeout never blocks, differences wrap modulo 2^32
      poll_due = poll_period != 16'd0 && (now_ms - query_ms) >= {16'd0, poll_period} &&
                 !(awaiting && (now_ms - request_ms) < {16'd0, timeout_ms}) && !busy;
      if (poll_due) begin
        awaiting   = 1'b1;
        request_ms = now_ms;
        query_ms   = now_ms;
        status_due.push_back(status_now(1'b1, dev_addr, 1'b0));
        status_due.push_back(status_now(1'b1, CODE_POSITION, 1'b0));
        status_due.push_back(status_now(1'b1, FRAME_TRAILER, 1'b1));
      end else begin
        status_due.push_back(status_now(1'b0, 8'h00, 1'b1));
      end
    end
  endtask

  task automatic check_word(input status_word_t want);
    if (out_tx_valid !== want.tx_valid)
      report_mismatch("tx_valid", out_tx_valid, want.tx_valid);
    if (out_tx_byte !== want.tx_byte)
      report_mismatch("tx_byte", out_tx_byte, want.tx_byte);
    if (out_last !== want.last)
      report_mismatch("last", out_last, want.last);
    if (out_position !== want.position)
      report_mismatch("position", out_position, want.position);
    if (out_position_valid !== want.position_valid)
      report_mismatch("position_valid", out_position_valid, want.position_valid);
    if (out_age_ms !== want.age_ms)
      report_mismatch("age_ms", out_age_ms, want.age_ms);
    if (out_request_pending !== want.request_pending)
      report_mismatch("request_pending", out_request_pending, want.request_pending);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_addr      = DEVICE_ADDRESS_RESET;
      poll_period   = QUERY_PERIOD_RESET;
      timeout_ms    = REQUEST_TIMEOUT_RESET;
      frame_pos     = '0;
      held_position = '0;
      update_ms     = '0;
      request_ms    = '0;
      query_ms      = '0;
      now_ms        = '0;
      have_fix      = 1'b0;
      awaiting      = 1'b0;
      fail_count    = 0;
      results_seen  = 0;
      requests_seen = 0;
      frames_taken  = 0;
      status_due.delete();
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (status_due.size() == 0) begin
          report_mismatch("word with nothing due, tx_byte", out_tx_byte, 32'h0);
        end else begin
          check_word(status_due.pop_front());
        end
        if (out_tx_valid === 1'b1 && out_last === 1'b1) requests_seen++;
        results_seen++;
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        predict_word(in_action, in_rx_byte, in_tx_busy);
      end
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS:  dev_addr    = cfg_data[7:0];
          CFG_QUERY_PERIOD:    poll_period = cfg_data;
          CFG_REQUEST_TIMEOUT: timeout_ms  = cfg_data;
          default: ;
        endcase
      end
    end
    words_due = status_due.size();
  end

endmodule

### tb/position_reply_link_tb.sv
// ----------------------------------------------------------------------------
// position_reply_link_tb
// drives the position reply link with received bytes and millisecond ticks:
// a short directed run over the parser corner cases, then register settings
// from the extremes to random ones, each with a mix of well-formed reply
// frames, broken frames, stray bytes and tick bursts, under random idling
// and back-pressure in most settings; the checker predicts every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module position_reply_link_tb;
  import prl_pkg::*;

  localparam int GAP_MAX      = 17;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   fail_count;
  int   words_due;
  int   results_seen;
  int   requests_seen;
  int   frames_taken;
  int   words_sent;
  int   ticks_sent;
  int   settings_used;
  int   cycle_count = 0;
  logic [7:0] link_addr;
  logic quiet_in;
  logic quiet_out;

  prl_in_if  in_ch ();
  prl_out_if out_ch ();

  position_reply_link dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  position_reply_link_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_action           (in_ch.action),
    .in_rx_byte          (in_ch.rx_byte),
    .in_tx_busy          (in_ch.tx_busy),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_tx_valid        (out_ch.tx_valid),
    .out_tx_byte         (out_ch.tx_byte),
    .out_last            (out_ch.last),
    .out_position        (out_ch.position),
    .out_position_valid  (out_ch.position_valid),
    .out_age_ms          (out_ch.age_ms),
    .out_request_pending (out_ch.request_pending),
    .fail_count          (fail_count),
    .words_due           (words_due),
    .results_seen        (results_seen),
    .requests_seen       (requests_seen),
    .frames_taken        (frames_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit with %0d words still due", words_due);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall before taking each word, unless quiet_out is set
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic action, input logic [7:0] b, input logic busy);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= action;
    in_ch.rx_byte <= b;
    in_ch.tx_busy <= busy;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    words_sent++;
    if (action == ACTION_TICK) ticks_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(ACTION_RX_BYTE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick();
    send_word(ACTION_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  task automatic send_frame(input logic [7:0] sign, input logic [31:0] mag,
                            input logic [7:0] trailer, input logic mixed);
    logic [7:0] frame [FRAME_LENGTH];
    frame = '{link_addr, CODE_POSITION, sign, mag[31:24], mag[23:16], mag[15:8], mag[7:0],
              trailer};
    foreach (frame[i]) begin
      if (mixed && $urandom_range(0, 9) == 0) send_tick();
      send_byte(frame[i]);
    end
  endtask

  function automatic logic [31:0] pick_magnitude();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1000);
      1: return $urandom;
      2: return ($urandom_range(0, 1) != 0) ? MAG_LIMIT : ~MAG_LIMIT;
      default: return $urandom & MAG_LIMIT;
    endcase
  endfunction

  task automatic random_sequence();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_frame(8'($urandom_range(0, 1)), pick_magnitude(), FRAME_TRAILER, 1'b1);
    end else if (pick < 58) begin
      b = 8'($urandom_range(0, 255));
      if (b == FRAME_TRAILER) b = b ^ 8'h01;
      send_frame(8'($urandom_range(0, 1)), pick_magnitude(), b, 1'b1);
    end else if (pick < 64) begin
      send_frame(8'($urandom_range(2, 255)), pick_magnitude(), FRAME_TRAILER, 1'b1);
    end else if (pick < 70) begin
      send_byte(link_addr);
      if ($urandom_range(0, 1) != 0) send_byte(link_addr);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      send_byte(($urandom_range(0, 3) == 0) ? link_addr : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_tick();
    end
  endtask

  // wait until every result word has been taken and the block is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [7:0] addr, input logic [15:0] period,
                              input logic [15:0] timeout, input logic spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_data  <= {8'($urandom_range(0, 255)), addr};
    @(negedge clk);
    cfg_index <= CFG_QUERY_PERIOD;
    cfg_data  <= period;
    @(negedge clk);
    cfg_index <= CFG_REQUEST_TIMEOUT;
    cfg_data  <= timeout;
    @(negedge clk);
    if (spare) begin
      cfg_index <= CFG_SPARE_INDEX;
      cfg_data  <= 16'($urandom_range(0, 65535));
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    link_addr = addr;
    settings_used++;
  endtask

  task automatic run_setting(input logic [7:0] addr, input logic [15:0] period,
                             input logic [15:0] timeout, input int count,
                             input logic calm_in, input logic calm_out, input logic spare);
    int first;
    settle();
    write_config(addr, period, timeout, spare);
    quiet_in  = calm_in;
    quiet_out = calm_out;
    first     = words_sent;
    while (words_sent - first < count) random_sequence();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DEVICE_ADDRESS;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACTION_RX_BYTE;
    in_ch.rx_byte = 8'h00;
    in_ch.tx_busy = 1'b0;
    quiet_in      = 1'b0;
    quiet_out     = 1'b0;
    link_addr     = DEVICE_ADDRESS_RESET;
    words_sent    = 0;
    ticks_sent    = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: repeated address, negative saturation, restart, request timing
    write_config(DEVICE_ADDRESS_RESET, 16'd2, REQUEST_TIMEOUT_RESET, 1'b0);
    send_word(ACTION_RX_BYTE, link_addr, 1'b0);
    send_frame(8'd1, 32'hFFFF_FFFF, FRAME_TRAILER, 1'b0);
    send_word(ACTION_RX_BYTE, link_addr, 1'b1);
    send_word(ACTION_RX_BYTE, 8'h00, 1'b0);
    send_frame(8'd0, 32'h0000_002A, FRAME_TRAILER, 1'b0);
    send_word(ACTION_TICK, 8'hFF, 1'b1);
    send_word(ACTION_TICK, 8'h00, 1'b1);
    send_word(ACTION_TICK, 8'hA5, 1'b0);
    send_word(ACTION_TICK, 8'h5A, 1'b0);

    run_setting(8'h00, 16'd1, 16'd0, 35, 1'b0, 1'b0, 1'b0);
    run_setting(8'hFF, 16'd3, 16'hFFFF, 35, 1'b0, 1'b0, 1'b0);
    run_setting(8'($urandom_range(0, 255)), 16'd0, 16'($urandom_range(0, 20)), 30,
                1'b0, 1'b0, 1'b1);
    run_setting(8'($urandom_range(0, 255)), 16'hFFFF, 16'd0, 25, 1'b1, 1'b0, 1'b0);
    run_setting(8'($urandom_range(0, 255)), 16'($urandom_range(1, 6)),
                16'($urandom_range(0, 10)), 40, 1'b0, 1'b1, 1'b0);
    run_setting(8'($urandom_range(0, 255)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 8)), 40, 1'b1, 1'b1, 1'b0);

    settle();
    $display("covered %0d input words (%0d ticks) over %0d register settings",
             words_sent, ticks_sent, settings_used);
    $display("took %0d result words: %0d requests sent, %0d position frames accepted",
             results_seen, requests_seen, frames_taken);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
